// ===== rtl/tpb_pkg.sv =====
package tpb_pkg;

   // table geometry
   localparam int SLOTS     = 8;
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int ADDR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAX_RES   = 16;
   localparam int RES_W     = $clog2(MAX_RES + 1);
   localparam int RES_X_W   = RES_W + 1;
   localparam int LIMIT_W   = 4;
   localparam int LIM_CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

   // operation codes
   localparam logic [2:0] OP_REG_PERIODIC = 3'd0;
   localparam logic [2:0] OP_REG_ONESHOT  = 3'd1;
   localparam logic [2:0] OP_DEREGISTER   = 3'd2;
   localparam logic [2:0] OP_TICK         = 3'd3;
   localparam logic [2:0] OP_OFFER        = 3'd4;

   // event codes
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_FIRED   = 2'd1;
   localparam logic [1:0] EV_REMOVED = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_NOT_DUE   = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  timer_id;
      logic [31:0] period_ms;
      logic [31:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] event_id;
      logic [2:0] status;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  handle;
      logic [31:0] period;
      logic [31:0] last_fire;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // result handed from the sequencer to the output register
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_push_type;

endpackage

// ===== rtl/tpb_ram.sv =====
module tpb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tpb_ctrl.sv =====
module tpb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tpb_pkg::req_item_type         req_data,
   input  logic [tpb_pkg::LIMIT_W-1:0]   slot_limit,
   input  logic                          out_free,
   output tpb_pkg::rsp_push_type         push,
   output logic                          ram_we,
   output logic [tpb_pkg::ADDR_W-1:0]    ram_waddr,
   output logic [tpb_pkg::ENTRY_W-1:0]   ram_wdata,
   output logic                          ram_re,
   output logic [tpb_pkg::ADDR_W-1:0]    ram_raddr,
   input  logic [tpb_pkg::ENTRY_W-1:0]   ram_rdata
);
   import tpb_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_RD,
      S_EV,
      S_FIN2,
      S_STORE,
      S_END
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic [7:0]         id_ff, id_in;
   logic [31:0]        period_ff, period_in;
   logic [31:0]        now_ff, now_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   wr_ff, wr_in;
   logic [RES_W-1:0]   n_ff, n_in;
   logic               pend_valid_ff, pend_valid_in;
   rsp_item_type       pend_ff, pend_in;
   logic               full_ff, full_in;
   logic               hit_ff, hit_in;
   logic               present_ff, present_in;
   logic               stop_ff, stop_in;

   slot_entry_type     q;
   slot_entry_type     wentry;
   logic               match;
   logic               due;
   logic [31:0]        elapsed;
   logic               last_entry;
   logic               can_emit;
   logic               is_full;
   logic               overflow;
   logic [RES_X_W-1:0] need;
   logic [LIM_CMP_W-1:0] lim_eff;
   logic [CNT_W-1:0]   rd_next;
   rsp_item_type       final_item;

   assign q          = slot_entry_type'(ram_rdata);
   assign match      = (q.handle == id_ff);
   assign elapsed    = now_ff - q.last_fire;
   assign due        = (elapsed > q.period);
   assign rd_next    = rd_ff + CNT_W'(1);
   assign last_entry = (rd_next >= count_ff);
   // a new result may be created only if the older pending one can leave
   assign can_emit   = !pend_valid_ff || out_free;
   assign need       = (q.period == '0) ? RES_X_W'(2) : RES_X_W'(1);
   assign overflow   = ({1'b0, n_ff} + need) > RES_X_W'(MAX_RES);
   assign lim_eff    = (LIM_CMP_W'(slot_limit) > LIM_CMP_W'(SLOTS)) ?
                       LIM_CMP_W'(SLOTS) : LIM_CMP_W'(slot_limit);
   assign is_full    = (LIM_CMP_W'(count_ff) >= lim_eff);
   assign req_stall  = (state_ff != S_IDLE);
   assign ram_wdata  = ENTRY_W'(wentry);

   // single result of every operation but tick, and the last result of a tick
   always_comb begin
      final_item = '0;
      final_item.last = 1'b1;
      case (op_ff)
         OP_REG_PERIODIC: begin
            final_item.event_id = id_ff;
            if (full_ff) begin
               final_item.status = ST_FULL;
            end else if (hit_ff) begin
               final_item.status = ST_DUPLICATE;
            end else begin
               final_item.event_res = EV_FIRED;
            end
         end
         OP_REG_ONESHOT: begin
            if (full_ff) begin
               final_item.event_id = id_ff;
               final_item.status   = ST_FULL;
            end
         end
         OP_DEREGISTER: begin
            if (hit_ff) begin
               final_item.event_res = EV_REMOVED;
               final_item.event_id  = id_ff;
            end else begin
               final_item.status = ST_NOT_FOUND;
            end
         end
         OP_TICK: begin
            if (pend_valid_ff) begin
               final_item.event_res = pend_ff.event_res;
               final_item.event_id  = pend_ff.event_id;
               final_item.status    = pend_ff.status;
            end
         end
         OP_OFFER: begin
            final_item.event_id = id_ff;
            if (hit_ff) begin
               final_item.event_res = EV_FIRED;
            end else if (present_ff) begin
               final_item.status = ST_NOT_DUE;
            end else begin
               final_item.status = ST_NOT_FOUND;
            end
         end
         default: begin
            final_item.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      period_in     = period_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      full_in       = full_ff;
      hit_in        = hit_ff;
      present_in    = present_ff;
      stop_in       = stop_ff;
      push          = '0;
      ram_we        = 1'b0;
      ram_waddr     = rd_ff[ADDR_W-1:0];
      ram_re        = 1'b0;
      ram_raddr     = rd_ff[ADDR_W-1:0];
      wentry        = q;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_data.operation;
               id_in         = req_data.timer_id;
               period_in     = req_data.period_ms;
               now_in        = req_data.now_ms;
               rd_in         = '0;
               wr_in         = '0;
               n_in          = '0;
               pend_valid_in = 1'b0;
               full_in       = 1'b0;
               hit_in        = 1'b0;
               present_in    = 1'b0;
               stop_in       = 1'b0;
               state_in      = S_START;
            end
         end
         S_START: begin
            case (op_ff)
               OP_REG_PERIODIC: begin
                  if (is_full) begin
                     full_in  = 1'b1;
                     state_in = S_END;
                  end else if (count_ff == '0) begin
                     state_in = S_STORE;
                  end else begin
                     state_in = S_RD;
                  end
               end
               OP_REG_ONESHOT: begin
                  full_in  = is_full;
                  state_in = is_full ? S_END : S_STORE;
               end
               OP_DEREGISTER, OP_TICK, OP_OFFER: begin
                  state_in = (count_ff == '0) ? S_END : S_RD;
               end
               default: begin
                  state_in = S_END;
               end
            endcase
         end
         S_RD: begin
            ram_re   = 1'b1;
            state_in = S_EV;
         end
         S_EV: begin
            case (op_ff)
               OP_REG_PERIODIC: begin
                  if (match) begin
                     hit_in   = 1'b1;
                     state_in = S_END;
                  end else begin
                     rd_in    = rd_next;
                     state_in = last_entry ? S_STORE : S_RD;
                  end
               end
               OP_OFFER: begin
                  if (match) begin
                     present_in = 1'b1;
                  end
                  if (match && due) begin
                     wentry.last_fire = now_ff;
                     ram_we   = 1'b1;
                     hit_in   = 1'b1;
                     state_in = S_END;
                  end else begin
                     rd_in    = rd_next;
                     state_in = last_entry ? S_END : S_RD;
                  end
               end
               OP_DEREGISTER: begin
                  if (!hit_ff && match) begin
                     hit_in = 1'b1;
                  end else begin
                     ram_we    = (wr_ff != rd_ff);
                     ram_waddr = wr_ff[ADDR_W-1:0];
                     wr_in     = wr_ff + CNT_W'(1);
                  end
                  rd_in    = rd_next;
                  state_in = last_entry ? S_END : S_RD;
               end
               OP_TICK: begin
                  if (!stop_ff && due && !overflow) begin
                     if (can_emit) begin
                        if (pend_valid_ff) begin
                           push.valid = 1'b1;
                           push.item  = pend_ff;
                        end
                        pend_valid_in      = 1'b1;
                        pend_in            = '0;
                        pend_in.event_res  = EV_FIRED;
                        pend_in.event_id   = q.handle;
                        n_in               = n_ff + RES_W'(1);
                        rd_in              = rd_next;
                        if (q.period == '0) begin
                           // one-shot: dropped from the table after its removal event
                           state_in = S_FIN2;
                        end else begin
                           wentry.last_fire = now_ff;
                           ram_we    = 1'b1;
                           ram_waddr = wr_ff[ADDR_W-1:0];
                           wr_in     = wr_ff + CNT_W'(1);
                           state_in  = last_entry ? S_END : S_RD;
                        end
                     end
                  end else begin
                     // not due, or out of result room: entry only slides down
                     if (!stop_ff && due) begin
                        stop_in = 1'b1;
                     end
                     ram_we    = (wr_ff != rd_ff);
                     ram_waddr = wr_ff[ADDR_W-1:0];
                     wr_in     = wr_ff + CNT_W'(1);
                     rd_in     = rd_next;
                     state_in  = last_entry ? S_END : S_RD;
                  end
               end
               default: begin
                  state_in = S_END;
               end
            endcase
         end
         S_FIN2: begin
            if (can_emit) begin
               push.valid          = 1'b1;
               push.item           = pend_ff;
               pend_in             = '0;
               pend_in.event_res   = EV_REMOVED;
               pend_in.event_id    = pend_ff.event_id;
               n_in                = n_ff + RES_W'(1);
               state_in            = (rd_ff >= count_ff) ? S_END : S_RD;
            end
         end
         S_STORE: begin
            ram_we           = 1'b1;
            ram_waddr        = count_ff[ADDR_W-1:0];
            wentry.handle    = id_ff;
            wentry.period    = (op_ff == OP_REG_PERIODIC) ? period_ff : '0;
            wentry.last_fire = now_ff;
            count_in         = count_ff + CNT_W'(1);
            state_in         = S_END;
         end
         S_END: begin
            if (out_free) begin
               push.valid    = 1'b1;
               push.item     = final_item;
               pend_valid_in = 1'b0;
               if (op_ff == OP_DEREGISTER || op_ff == OP_TICK) begin
                  count_in = wr_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
      end
      op_ff      <= op_in;
      id_ff      <= id_in;
      period_ff  <= period_in;
      now_ff     <= now_in;
      rd_ff      <= rd_in;
      wr_ff      <= wr_in;
      n_ff       <= n_in;
      pend_ff    <= pend_in;
      full_ff    <= full_in;
      hit_ff     <= hit_in;
      present_ff <= present_in;
      stop_ff    <= stop_in;
   end

   // compaction never writes ahead of the scan
   a_wr_behind_rd : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EV || state_ff == S_RD || state_ff == S_FIN2) |-> (wr_ff <= rd_ff))
      else $error("compaction pointer passed scan pointer");

   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!pend_valid_ff && !ram_we && !push.valid))
      else $error("activity while idle");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_free)
      else $error("result pushed into a full output register");

   a_store_room : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE) |-> (count_ff < CNT_W'(SLOTS)))
      else $error("store beyond table depth");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END && out_free) |=> (state_ff == S_IDLE && count_ff <= CNT_W'(SLOTS)))
      else $error("sequencer did not retire item");

endmodule

// ===== rtl/periodic_timer_bank_unit.sv =====
// sequencing: register checks the limit, then searches the slots for a duplicate and stores;
//   one-shot register checks the limit and stores; deregister, tick and offer scan the slots,
//   and tick takes an extra step for each one-shot that it removes
// flow: one item at a time; each slot visit is a registered read, then a modify/write of the
//   slot memory, which has separate read and write ports
// reset: slot count cleared, slot_limit back to 8, output register emptied; the slot memory
//   is not cleared since only entries below the count are ever read
module periodic_timer_bank_unit (
   input  logic                        clock,
   input  logic                        reset,
   // request items
   input  logic                        req_valid,
   output logic                        req_stall,
   input  tpb_pkg::req_item_type       req_data,
   // result items
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tpb_pkg::rsp_item_type       rsp_data,
   // slot_limit register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tpb_pkg::LIMIT_W-1:0] csr_data
);
   import tpb_pkg::*;

   // configuration
   logic [LIMIT_W-1:0] slot_limit_ff, slot_limit_in;

   // output register between the sequencer and the result channel
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;
   logic               out_free;

   rsp_push_type       push;

   // slot memory port
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   // writes must come only while idle; the block itself does not enforce that, and the register is always ready
   assign csr_ready     = 1'b1;
   assign slot_limit_in = (csr_valid && csr_ready) ? csr_data : slot_limit_ff;

   // sequencer may hand over a new item whenever the register empties this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push.item;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_limit_ff <= LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_limit_ff <= slot_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // handle, period and last fire time of every slot, one word per slot
   tpb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // per-item sequencer: search, fire, compact, store
   tpb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .slot_limit (slot_limit_ff),
      .out_free   (out_free),
      .push       (push),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

endmodule

// ===== verif/periodic_timer_bank_unit_tb.sv =====
`timescale 1ns / 100ps

module periodic_timer_bank_unit_tb;
   import tpb_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;   // far above the slowest legal run
   localparam int DRAIN_CYCLES = 60;       // full tick scan of eight slots plus output slack
   localparam int LONG_HOLD    = 300;      // receiver hold-off while the sender keeps pushing
   localparam int CROWD_ITEMS  = 40;
   localparam int PHASE_ITEMS  = 64;

   // expected result items, predicted from a private copy of the timer table
   class timer_event_scoreboard;
      logic [7:0]         slot_id       [SLOTS];
      logic [31:0]        slot_period   [SLOTS];
      logic [31:0]        slot_fired_at [SLOTS];
      int                 used;
      logic [LIMIT_W-1:0] limit;
      rsp_item_type       batch[$];
      rsp_item_type       pending_events[$];
      int                 mismatches;
      int                 events_checked;

      function new();
         used           = 0;
         limit          = LIMIT_RESET;
         mismatches     = 0;
         events_checked = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit = value;
      endfunction

      function int usable_slots();
         return (limit > SLOTS) ? SLOTS : int'(limit);
      endfunction

      function bit is_due(int pos, logic [31:0] now);
         logic [31:0] elapsed;
         elapsed = now - slot_fired_at[pos];
         return elapsed > slot_period[pos];
      endfunction

      function void add_slot(logic [7:0] id, logic [31:0] period, logic [31:0] now);
         slot_id[used]       = id;
         slot_period[used]   = period;
         slot_fired_at[used] = now;
         used++;
      endfunction

      // remove one entry and keep the rest in registration order
      function void drop_slot(int pos);
         for (int k = pos; k + 1 < used; k++) begin
            slot_id[k]       = slot_id[k + 1];
            slot_period[k]   = slot_period[k + 1];
            slot_fired_at[k] = slot_fired_at[k + 1];
         end
         used--;
      endfunction

      function void queue_event(logic [1:0] ev, logic [7:0] id, logic [2:0] st);
         rsp_item_type item;
         if (batch.size() < MAX_RES) begin
            item.event_res = ev;
            item.event_id  = id;
            item.status    = st;
            item.last      = 1'b0;
            batch.push_back(item);
         end
      endfunction

      function void note_request(req_item_type rq);
         int           pos;
         bit           hit;
         bit           fired;
         bit           stop;
         rsp_item_type tail;
         batch.delete();
         case (rq.operation)
            OP_REG_PERIODIC, OP_REG_ONESHOT: begin
               hit = 1'b0;
               for (int k = 0; k < used; k++)
                  if (slot_id[k] == rq.timer_id) hit = 1'b1;
               if (used >= usable_slots()) begin
                  queue_event(EV_NONE, rq.timer_id, ST_FULL);
               end else if (rq.operation == OP_REG_ONESHOT) begin
                  add_slot(rq.timer_id, '0, rq.now_ms);
                  queue_event(EV_NONE, 8'd0, ST_OK);
               end else if (hit) begin
                  queue_event(EV_NONE, rq.timer_id, ST_DUPLICATE);
               end else begin
                  add_slot(rq.timer_id, rq.period_ms, rq.now_ms);
                  queue_event(EV_FIRED, rq.timer_id, ST_OK);
               end
            end
            OP_DEREGISTER: begin
               pos = -1;
               for (int k = 0; k < used && pos < 0; k++)
                  if (slot_id[k] == rq.timer_id) pos = k;
               if (pos >= 0) begin
                  drop_slot(pos);
                  queue_event(EV_REMOVED, rq.timer_id, ST_OK);
               end else begin
                  queue_event(EV_NONE, 8'd0, ST_NOT_FOUND);
               end
            end
            OP_TICK: begin
               pos  = 0;
               stop = 1'b0;
               while (pos < used && !stop) begin
                  if (!is_due(pos, rq.now_ms)) begin
                     pos++;
                  end else if (batch.size() + ((slot_period[pos] == 0) ? 2 : 1) > MAX_RES) begin
                     stop = 1'b1;
                  end else begin
                     slot_fired_at[pos] = rq.now_ms;
                     queue_event(EV_FIRED, slot_id[pos], ST_OK);
                     if (slot_period[pos] == 0) begin
                        queue_event(EV_REMOVED, slot_id[pos], ST_OK);
                        drop_slot(pos);
                     end else begin
                        pos++;
                     end
                  end
               end
               if (batch.size() == 0) queue_event(EV_NONE, 8'd0, ST_OK);
            end
            OP_OFFER: begin
               hit   = 1'b0;
               fired = 1'b0;
               for (int k = 0; k < used && !fired; k++) begin
                  if (slot_id[k] == rq.timer_id) begin
                     hit = 1'b1;
                     if (is_due(k, rq.now_ms)) begin
                        slot_fired_at[k] = rq.now_ms;
                        fired = 1'b1;
                     end
                  end
               end
               if (fired) queue_event(EV_FIRED, rq.timer_id, ST_OK);
               else queue_event(EV_NONE, rq.timer_id, hit ? ST_NOT_DUE : ST_NOT_FOUND);
            end
            default: begin
               queue_event(EV_NONE, 8'd0, ST_OK);
            end
         endcase
         tail = batch.pop_back();
         tail.last = 1'b1;
         batch.push_back(tail);
         for (int k = 0; k < batch.size(); k++) pending_events.push_back(batch[k]);
      endfunction

      function void report(string field, int want, int got);
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      endfunction

      function void check_event(rsp_item_type got);
         rsp_item_type want;
         events_checked++;
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual %0d/%0d/%0d/%0d",
                     $time, got.event_res, got.event_id, got.status, got.last);
            mismatches++;
            return;
         end
         want = pending_events.pop_front();
         if (got.event_res !== want.event_res) report("event_res", want.event_res, got.event_res);
         if (got.event_id !== want.event_id) report("event_id", want.event_id, got.event_id);
         if (got.status !== want.status) report("status", want.status, got.status);
         if (got.last !== want.last) report("last", want.last, got.last);
      endfunction
   endclass

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_item_type        req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_item_type        rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_data  = '0;

   timer_event_scoreboard timer_sb;

   logic [31:0] ms_now;          // free-running millisecond base for generated items
   int          op_count [8];
   int          limit_writes;
   int          cycles = 0;

   // receiver side: hold-off requests from the stimulus, else a rotating stall mask
   int          hold_asked  = 0;
   int          hold_served = 0;
   int          hold_left   = 0;
   int          stall_phase = 0;
   logic [15:0] stall_mask  = '0;

   periodic_timer_bank_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_served != hold_asked) begin
         // long hold-off so the block backs up into its input
         hold_served <= hold_asked;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= stall_mask[stall_phase % 16];
         if (stall_phase == 63) begin
            stall_phase <= 0;
            // new mask: clean, random, light or heavy stalling
            case ($urandom_range(0, 3))
               0: stall_mask <= '0;
               1: stall_mask <= 16'($urandom);
               2: stall_mask <= 16'($urandom & $urandom);
               default: stall_mask <= 16'($urandom | $urandom);
            endcase
         end else begin
            stall_phase <= stall_phase + 1;
         end
      end
   end

   // result monitor: every accepted result item goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) timer_sb.check_event(rsp_data);
   end

   function automatic req_item_type make_req(logic [2:0] op, logic [7:0] id,
                                             logic [31:0] period, logic [31:0] now);
      req_item_type rq;
      rq.operation = op;
      rq.timer_id  = id;
      rq.period_ms = period;
      rq.now_ms    = now;
      return rq;
   endfunction

   // random item shaped around the current table so hits, duplicates and due timers happen
   function automatic req_item_type random_request();
      req_item_type rq;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 22) rq.operation = OP_REG_PERIODIC;
      else if (pick < 37) rq.operation = OP_REG_ONESHOT;
      else if (pick < 52) rq.operation = OP_DEREGISTER;
      else if (pick < 77) rq.operation = OP_TICK;
      else if (pick < 95) rq.operation = OP_OFFER;
      else rq.operation = 3'($urandom_range(5, 7));

      pick = $urandom_range(0, 99);
      if (pick < 25 && timer_sb.used > 0)
         rq.timer_id = timer_sb.slot_id[$urandom_range(0, timer_sb.used - 1)];
      else if (pick < 85) rq.timer_id = 8'($urandom_range(0, 11));
      else rq.timer_id = 8'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 10) rq.period_ms = '0;
      else if (pick < 60) rq.period_ms = $urandom_range(1, 12);
      else if (pick < 85) rq.period_ms = $urandom_range(13, 300);
      else rq.period_ms = $urandom;

      // time mostly moves forward and wraps; now and then a wild value
      ms_now = ms_now + $urandom_range(0, 8);
      rq.now_ms = ($urandom_range(0, 99) < 4) ? 32'($urandom) : ms_now;
      return rq;
   endfunction

   task automatic send_item(input req_item_type rq);
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      timer_sb.note_request(rq);
      op_count[rq.operation]++;
   endtask

   task automatic go_quiet(input int gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   // sender stops until every expected result item is back, then lets the block settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (timer_sb.pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      timer_sb.set_limit(value);
      limit_writes++;
   endtask

   task automatic run_phase(input int count, input bit crowd);
      int sent;
      int burst;
      sent = 0;
      if (crowd) begin
         // receiver freezes while a long unbroken burst keeps coming
         hold_asked <= hold_asked + 1;
         repeat (CROWD_ITEMS) send_item(random_request());
         sent = CROWD_ITEMS;
      end
      while (sent < count) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
         for (int b = 0; b < burst && sent < count; b++) begin
            send_item(random_request());
            sent++;
         end
         go_quiet($urandom_range(1, 6));
      end
   endtask

   initial begin
      logic [LIMIT_W-1:0] phase_limit [7];
      timer_sb     = new();
      limit_writes = 0;
      ms_now       = 32'hFFFF_FE00;   // random part crosses the 32-bit wrap
      foreach (op_count[k]) op_count[k] = 0;
      phase_limit  = '{4'd15, 4'd2, 4'd0, 4'd8, 4'd5, 4'd1, 4'd8};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table cases
      send_item(make_req(OP_TICK, 8'd0, 32'd0, 32'd100));           // quiet tick
      send_item(make_req(OP_OFFER, 8'd5, 32'd0, 32'd100));          // offer, unknown handle
      send_item(make_req(OP_DEREGISTER, 8'd5, 32'd0, 32'd100));     // deregister, unknown
      // registration extremes and duplicate refusal
      send_item(make_req(OP_REG_PERIODIC, 8'd0, 32'd0, 32'd0));
      send_item(make_req(OP_REG_PERIODIC, 8'd0, 32'd7, 32'd0));
      send_item(make_req(OP_REG_PERIODIC, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // one-shots may repeat a handle; period field is ignored
      send_item(make_req(OP_REG_ONESHOT, 8'd7, 32'd123, 32'd10));
      send_item(make_req(OP_REG_ONESHOT, 8'd7, 32'hFFFF_FFFF, 32'd10));
      // offers: not due across the wrap, due, one-shot fires but stays, same-ms repeat
      send_item(make_req(OP_OFFER, 8'd255, 32'd0, 32'd5));
      send_item(make_req(OP_OFFER, 8'd0, 32'd0, 32'd1));
      send_item(make_req(OP_OFFER, 8'd7, 32'd0, 32'd11));
      send_item(make_req(OP_OFFER, 8'd0, 32'd0, 32'd1));
      // tick retires the zero-period periodic and both one-shots
      send_item(make_req(OP_TICK, 8'd99, 32'd0, 32'd20));
      // unknown operation codes
      send_item(make_req(3'd5, 8'hAA, 32'hFFFF_FFFF, 32'd20));
      send_item(make_req(3'd7, 8'h55, 32'd0, 32'd20));
      send_item(make_req(OP_DEREGISTER, 8'd255, 32'd0, 32'd20));
      // fill the table with seven one-shots and a periodic, then one registration too many
      for (int k = 0; k < 7; k++)
         send_item(make_req(OP_REG_ONESHOT, 8'h80 + 8'(k), 32'd0, 32'd30));
      send_item(make_req(OP_REG_PERIODIC, 8'hAA, 32'd4, 32'd30));
      send_item(make_req(OP_REG_ONESHOT, 8'hBB, 32'd0, 32'd30));
      // big tick: one fire plus seven fire-and-remove pairs
      send_item(make_req(OP_TICK, 8'd0, 32'd0, 32'd40));

      // random phases under changing limits, including zero and out-of-range
      for (int p = 0; p < 7; p++) begin
         write_limit((p == 6) ? 4'($urandom_range(0, 15)) : phase_limit[p]);
         run_phase(PHASE_ITEMS, p == 3);
      end

      wait_drained();
      $display("covered %0d periodic, %0d one-shot, %0d deregister, %0d tick, %0d offer items",
               op_count[OP_REG_PERIODIC], op_count[OP_REG_ONESHOT], op_count[OP_DEREGISTER],
               op_count[OP_TICK], op_count[OP_OFFER]);
      $display("plus %0d unknown-code items; %0d result items checked over %0d limit writes",
               op_count[5] + op_count[6] + op_count[7], timer_sb.events_checked, limit_writes);
      if (timer_sb.mismatches == 0 && timer_sb.pending_events.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
